// ----- design/jsu_pkg.sv -----
// Package with the shared types, codes and helper functions of the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned KindW = 3;
  localparam int unsigned ModeW = 2;
  localparam int unsigned HexCntW = 2;

  localparam logic [ModeW-1:0] MODE_WAIT = 2'd0;
  localparam logic [ModeW-1:0] MODE_STR  = 2'd1;
  localparam logic [ModeW-1:0] MODE_ESC  = 2'd2;
  localparam logic [ModeW-1:0] MODE_HEX  = 2'd3;

  localparam logic [KindW-1:0] KIND_UNIT   = 3'd0;
  localparam logic [KindW-1:0] KIND_CLOSE  = 3'd1;
  localparam logic [KindW-1:0] KIND_BADESC = 3'd2;
  localparam logic [KindW-1:0] KIND_BADHEX = 3'd3;
  localparam logic [KindW-1:0] KIND_UNTERM = 3'd4;
  localparam logic [KindW-1:0] KIND_NOOPEN = 3'd5;

  localparam logic [UnitW-1:0] CH_QUOTE = 16'h0022;
  localparam logic [UnitW-1:0] CH_BSLASH = 16'h005C;
  localparam logic [UnitW-1:0] CH_SLASH = 16'h002F;
  localparam logic [UnitW-1:0] CH_B = 16'h0062;
  localparam logic [UnitW-1:0] CH_F = 16'h0066;
  localparam logic [UnitW-1:0] CH_N = 16'h006E;
  localparam logic [UnitW-1:0] CH_R = 16'h0072;
  localparam logic [UnitW-1:0] CH_T = 16'h0074;
  localparam logic [UnitW-1:0] CH_U = 16'h0075;
  localparam logic [UnitW-1:0] CH_BS = 16'h0008;
  localparam logic [UnitW-1:0] CH_FF = 16'h000C;
  localparam logic [UnitW-1:0] CH_LF = 16'h000A;
  localparam logic [UnitW-1:0] CH_CR = 16'h000D;
  localparam logic [UnitW-1:0] CH_TAB = 16'h0009;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             text_end;
  } item_t;

  typedef struct packed {
    logic             vld;
    logic [UnitW-1:0] out_unit;
    logic [KindW-1:0] kind;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [UnitW-1:0] u);
    hex_t h;
    h.ok = 1'b1;
    h.val = 4'd0;
    if (u >= 16'h0030 && u <= 16'h0039) begin
      h.val = 4'(u - 16'h0030);
    end else if (u >= 16'h0061 && u <= 16'h0066) begin
      h.val = 4'(u - 16'h0061 + 16'd10);
    end else if (u >= 16'h0041 && u <= 16'h0046) begin
      h.val = 4'(u - 16'h0041 + 16'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- design/jsu_in_reg.sv -----
// Input register stage that holds one accepted code unit until the decoder consumes it.
module jsu_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  jsu_pkg::item_t item_i,
  input  logic          consume_i,
  output logic          item_vld_o,
  output jsu_pkg::item_t item_o
);
  import jsu_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q, item_d;
  logic  take;

  assign s_tready_o = !vld_q || consume_i;
  assign take = s_tvalid_i && s_tready_o;

  always_comb begin
    vld_d = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d = 1'b1;
      item_d = item_i;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_vld_o = vld_q;
  assign item_o = item_q;
endmodule

// ----- design/jsu_decode.sv -----
// String decoder state and the per-unit decoding of quotes, escapes and hex digits.
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  jsu_pkg::item_t  item_i,
  output jsu_pkg::result_t res_o
);
  import jsu_pkg::*;

  logic [ModeW-1:0]   mode_q, mode_d;
  logic [UnitW-1:0]   acc_q, acc_d;
  logic [HexCntW-1:0] cnt_q, cnt_d;
  logic [UnitW-1:0]   u;
  logic [UnitW-1:0]   acc_next;
  hex_t               hx;

  assign u = item_i.code_unit;
  assign hx = hex_value(u);
  assign acc_next = {acc_q[UnitW-5:0], hx.val};

  always_comb begin
    mode_d = mode_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    res_o.vld = 1'b0;
    res_o.out_unit = '0;
    res_o.kind = KIND_UNIT;
    if (item_i.text_end) begin
      if (mode_q != MODE_WAIT) begin
        mode_d = MODE_WAIT;
        acc_d = '0;
        cnt_d = '0;
        res_o.vld = 1'b1;
        res_o.kind = KIND_UNTERM;
      end
    end else begin
      case (mode_q)
        MODE_WAIT: begin
          if (u == CH_QUOTE) begin
            mode_d = MODE_STR;
          end else begin
            res_o.vld = 1'b1;
            res_o.kind = KIND_NOOPEN;
          end
        end
        MODE_STR: begin
          if (u == CH_QUOTE) begin
            mode_d = MODE_WAIT;
            acc_d = '0;
            cnt_d = '0;
            res_o.vld = 1'b1;
            res_o.kind = KIND_CLOSE;
          end else if (u == CH_BSLASH) begin
            mode_d = MODE_ESC;
          end else begin
            res_o.vld = 1'b1;
            res_o.out_unit = u;
          end
        end
        MODE_ESC: begin
          mode_d = MODE_STR;
          res_o.vld = 1'b1;
          case (u)
            CH_QUOTE:  res_o.out_unit = CH_QUOTE;
            CH_BSLASH: res_o.out_unit = CH_BSLASH;
            CH_SLASH:  res_o.out_unit = CH_SLASH;
            CH_B:      res_o.out_unit = CH_BS;
            CH_F:      res_o.out_unit = CH_FF;
            CH_N:      res_o.out_unit = CH_LF;
            CH_R:      res_o.out_unit = CH_CR;
            CH_T:      res_o.out_unit = CH_TAB;
            CH_U: begin
              mode_d = MODE_HEX;
              acc_d = '0;
              cnt_d = '0;
              res_o.vld = 1'b0;
            end
            default: begin
              mode_d = MODE_WAIT;
              acc_d = '0;
              cnt_d = '0;
              res_o.kind = KIND_BADESC;
            end
          endcase
        end
        default: begin
          if (!hx.ok) begin
            mode_d = MODE_WAIT;
            acc_d = '0;
            cnt_d = '0;
            res_o.vld = 1'b1;
            res_o.kind = KIND_BADHEX;
          end else if (cnt_q == {HexCntW{1'b1}}) begin
            mode_d = MODE_STR;
            acc_d = '0;
            cnt_d = '0;
            res_o.vld = 1'b1;
            res_o.out_unit = acc_next;
          end else begin
            acc_d = acc_next;
            cnt_d = cnt_q + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_WAIT;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

// ----- design/jsu_out_reg.sv -----
// Result register that holds one decoded result until the downstream side takes it.
module jsu_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jsu_pkg::result_t res_i,
  output logic             free_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [jsu_pkg::UnitW-1:0] out_unit_o,
  output logic [jsu_pkg::KindW-1:0] kind_o
);
  import jsu_pkg::*;

  logic             vld_q, vld_d;
  logic [UnitW-1:0] unit_q;
  logic [KindW-1:0] kind_q;

  assign free_o = !vld_q || m_tready_i;

  always_comb begin
    if (load_i) begin
      vld_d = res_i.vld;
    end else begin
      vld_d = vld_q && !m_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.vld) begin
      unit_q <= res_i.out_unit;
      kind_q <= res_i.kind;
    end
  end

  assign m_tvalid_o = vld_q;
  assign out_unit_o = unit_q;
  assign kind_o = kind_q;
endmodule

// ----- design/json_string_unescape.sv -----
// Top level of the JSON string unescaper for a stream of UTF-16 code units.
// The block decodes quoted JSON strings one code unit per transfer and reports plain
// and escaped units, string ends and errors on the output stream, at most one result
// per input transfer. A code unit is held in an input register, decoded by a small
// state machine, and its result lands in an output register; the block accepts one
// transfer every cycle as long as the output side keeps taking results. Escapes of
// the form backslash-u with four hex digits give the code unit they spell, and any
// error sends the block back to waiting for an opening quote.
module json_string_unescape (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tuser,   // [0] text_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] out_unit
  output logic [2:0]  m_tuser    // [2:0] kind
);
  import jsu_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_vld;
  logic    out_free;
  logic    step;
  result_t res;

  assign in_item.code_unit = s_tdata;
  assign in_item.text_end = s_tuser;
  assign step = held_vld && out_free;

  jsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .item_i     (in_item),
    .consume_i  (step),
    .item_vld_o (held_vld),
    .item_o     (held_item)
  );

  jsu_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (held_item),
    .res_o  (res)
  );

  jsu_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (res),
    .free_o     (out_free),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .out_unit_o (m_tdata),
    .kind_o     (m_tuser)
  );
endmodule
